### src/cbh_pkg.sv
`default_nettype none

package cbh_pkg;

  localparam int NUM_CELLS = 4;
  localparam int MV_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = NUM_CELLS * MV_W;
  localparam int OUT_BITS  = NUM_CELLS + 1;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MV_W-1:0] MV_FULL_SCALE = 16'hFFFF;

  localparam logic [MV_W-1:0] START_DELTA_RESET = 16'd30;
  localparam logic [MV_W-1:0] STOP_DELTA_RESET  = 16'd10;
  localparam logic [MV_W-1:0] MIN_CELL_RESET    = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELTA = 2'd0,
    REG_STOP_DELTA  = 2'd1,
    REG_MIN_CELL    = 2'd2
  } cfg_reg_t;

  typedef logic [NUM_CELLS-1:0][MV_W-1:0] cell_vec_t;

  typedef struct packed {
    logic [MV_W-1:0] lo;
    logic [MV_W-1:0] hi;
    logic [MV_W-1:0] spread;
  } extrema_t;

  typedef struct packed {
    logic [MV_W-1:0] start_delta_mv;
    logic [MV_W-1:0] stop_delta_mv;
    logic [MV_W-1:0] min_cell_mv;
  } cfg_t;

endpackage

`default_nettype wire

### src/cell_balance_hysteresis.sv
// Passive cell balancing with hysteresis. Each input item is one sample of
// the four cell voltages (millivolts, unsigned 16 bit). The block takes one
// item per clock cycle while s_tready is high, and returns one result item
// per sample: the sample is held in an input register, the min/max/spread
// and threshold compares run in one pass, and the balance mask and
// hysteresis flag land in the output register. The flag is carried from
// sample to sample, so results follow input order. One sample can wait in
// the input register while a result is stalled at the output. Configuration
// registers (0 start delta, 1 stop delta, 2 minimum cell voltage) are
// written through cfg_we/cfg_index/cfg_data (index 3 is ignored); the user
// must write them only while the block is idle, which it does not enforce.
`default_nettype none

module cell_balance_hysteresis (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // cell_voltage_0 [15:0], cell_voltage_1 [31:16],
  // cell_voltage_2 [47:32], cell_voltage_3 [63:48]
  input  wire [cbh_pkg::IN_W-1:0]        s_tdata,
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // balance_mask [3:0], balancing_on [4], zero [7:5]
  output logic [cbh_pkg::OUT_W-1:0]      m_tdata,
  input  wire                            cfg_we,
  input  wire [cbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [cbh_pkg::MV_W-1:0]        cfg_data
);

  cbh_pkg::cfg_t      cfg;
  cbh_pkg::cell_vec_t cells;
  cbh_pkg::extrema_t  ext;
  logic               in_valid;
  logic               active;
  logic               active_next;
  logic               advance;
  logic [cbh_pkg::NUM_CELLS-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delta_mv <= cbh_pkg::START_DELTA_RESET;
      cfg.stop_delta_mv  <= cbh_pkg::STOP_DELTA_RESET;
      cfg.min_cell_mv    <= cbh_pkg::MIN_CELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbh_pkg::REG_START_DELTA: cfg.start_delta_mv <= cfg_data;
        cbh_pkg::REG_STOP_DELTA:  cfg.stop_delta_mv  <= cfg_data;
        cbh_pkg::REG_MIN_CELL:    cfg.min_cell_mv    <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register moves when empty or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      cells <= s_tdata;
    end
  end

  cbh_extrema u_extrema (
    .cells (cells),
    .ext   (ext)
  );

  cbh_decide u_decide (
    .cells       (cells),
    .ext         (ext),
    .cfg         (cfg),
    .active      (active),
    .active_next (active_next),
    .mask        (mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      active   <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        active <= active_next;
      end
    end
    if (advance && in_valid) begin
      m_tdata <= {{(cbh_pkg::OUT_W - cbh_pkg::OUT_BITS){1'b0}}, active_next, mask};
    end
  end

`ifndef SYNTHESIS
  a_mask_needs_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[cbh_pkg::NUM_CELLS] |-> m_tdata[cbh_pkg::NUM_CELLS-1:0] == '0)
    else $error("balance mask set while balancing is off");

  a_flag_tracks_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_valid |=> m_tdata[cbh_pkg::NUM_CELLS] == active)
    else $error("result flag differs from hysteresis state");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

### src/cbh_extrema.sv
`default_nettype none

module cbh_extrema (
  input  wire cbh_pkg::cell_vec_t cells,
  output cbh_pkg::extrema_t       ext
);

  logic [cbh_pkg::MV_W-1:0] lo;
  logic [cbh_pkg::MV_W-1:0] hi;

  always_comb begin
    lo = cbh_pkg::MV_FULL_SCALE;
    hi = '0;
    for (int i = 0; i < cbh_pkg::NUM_CELLS; i++) begin
      if (cells[i] < lo) begin
        lo = cells[i];
      end
      if (cells[i] > hi) begin
        hi = cells[i];
      end
    end
  end

  assign ext.lo     = lo;
  assign ext.hi     = hi;
  assign ext.spread = hi - lo;

endmodule

`default_nettype wire

### src/cbh_decide.sv
`default_nettype none

module cbh_decide (
  input  wire cbh_pkg::cell_vec_t           cells,
  input  wire cbh_pkg::extrema_t            ext,
  input  wire cbh_pkg::cfg_t                cfg,
  input  wire                               active,
  output logic                              active_next,
  output logic [cbh_pkg::NUM_CELLS-1:0]     mask
);

  logic [cbh_pkg::MV_W-1:0] half;
  logic [cbh_pkg::MV_W-1:0] floor_mv;

  // hysteresis: separate on and off thresholds
  always_comb begin
    if (!active) begin
      active_next = (ext.spread >= cfg.start_delta_mv) && (ext.lo >= cfg.min_cell_mv);
    end else begin
      active_next = !((ext.spread <= cfg.stop_delta_mv) || (ext.lo < cfg.min_cell_mv));
    end
  end

  assign half     = {1'b0, cfg.stop_delta_mv[cbh_pkg::MV_W-1:1]};
  // floor never drops below the lowest cell, so no wrap
  assign floor_mv = (half > ext.spread) ? ext.hi : (ext.hi - half);

  always_comb begin
    for (int i = 0; i < cbh_pkg::NUM_CELLS; i++) begin
      mask[i] = active_next && (cells[i] >= floor_mv) && (cells[i] > cfg.min_cell_mv);
    end
  end

endmodule

`default_nettype wire

### tb/balance_monitor.sv
`timescale 1ns / 100ps

module balance_monitor
  import cbh_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  input  wire                 s_tready,
  // cell_voltage_0 [15:0], cell_voltage_1 [31:16],
  // cell_voltage_2 [47:32], cell_voltage_3 [63:48]
  input  wire [IN_W-1:0]      s_tdata,
  input  wire                 m_tvalid,
  input  wire                 m_tready,
  // balance_mask [3:0], balancing_on [4], zero [7:5]
  input  wire [OUT_W-1:0]     m_tdata,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [MV_W-1:0]      cfg_data,
  output int                  mismatch_count,
  output int                  results_owed
);

  typedef struct packed {
    logic [NUM_CELLS-1:0] mask;
    logic                 flag;
  } balance_t;

  cfg_t     thresholds;
  logic     bleeding;
  balance_t owed_q[$];

  function automatic balance_t predict_balance(cell_vec_t cells, cfg_t t, logic was_on);
    logic [MV_W-1:0] lo, hi, spread, half, floor_mv;
    balance_t        r;
    int              i;
    lo = MV_FULL_SCALE;
    hi = '0;
    for (i = 0; i < NUM_CELLS; i++) begin
      if (cells[i] < lo) lo = cells[i];
      if (cells[i] > hi) hi = cells[i];
    end
    spread = hi - lo;
    r.flag = was_on;
    if (!was_on) begin
      if (spread >= t.start_delta_mv && lo >= t.min_cell_mv) r.flag = 1'b1;
    end else if (spread <= t.stop_delta_mv || lo < t.min_cell_mv) begin
      r.flag = 1'b0;
    end
    r.mask = '0;
    if (r.flag) begin
      // floor never drops below the lowest cell
      half     = t.stop_delta_mv >> 1;
      floor_mv = (half > spread) ? hi : hi - half;
      for (i = 0; i < NUM_CELLS; i++)
        if (cells[i] >= floor_mv && cells[i] > t.min_cell_mv) r.mask[i] = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    balance_t want, got;
    int       errs;
    errs = 0;
    if (rst) begin
      thresholds <= '{start_delta_mv: START_DELTA_RESET, stop_delta_mv: STOP_DELTA_RESET,
                      min_cell_mv: MIN_CELL_RESET};
      bleeding   <= 1'b0;
      owed_q.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_DELTA: thresholds.start_delta_mv <= cfg_data;
          REG_STOP_DELTA:  thresholds.stop_delta_mv  <= cfg_data;
          REG_MIN_CELL:    thresholds.min_cell_mv    <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.mask = m_tdata[NUM_CELLS-1:0];
        got.flag = m_tdata[NUM_CELLS];
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result item: expected none, actual %h", $time, m_tdata);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (got.mask !== want.mask) begin
            $display("%0t: balance_mask mismatch: expected %h, actual %h",
                     $time, want.mask, got.mask);
            errs++;
          end
          if (got.flag !== want.flag) begin
            $display("%0t: balancing_on mismatch: expected %b, actual %b",
                     $time, want.flag, got.flag);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_balance(cell_vec_t'(s_tdata), thresholds, bleeding);
        bleeding <= want.flag;
        owed_q.push_back(want);
      end
      mismatch_count <= mismatch_count + errs;
      results_owed   <= owed_q.size();
    end
  end

endmodule

### tb/cell_balance_hysteresis_test.sv
`timescale 1ns / 100ps

module cell_balance_hysteresis_test;
  import cbh_pkg::*;

  // index past the last register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SAMPLES_PER_PHASE = 105;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MV_W-1:0]      cfg_data  = '0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire [OUT_W-1:0]      m_tdata;

  int   mismatch_count;
  int   results_owed;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  cfg_t limits = '{start_delta_mv: START_DELTA_RESET, stop_delta_mv: STOP_DELTA_RESET,
                   min_cell_mv: MIN_CELL_RESET};

  cell_balance_hysteresis uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  balance_monitor monitor (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [MV_W-1:0] clamp_mv(int x);
    if (x < 0) return '0;
    if (x > 65535) return MV_FULL_SCALE;
    return x[MV_W-1:0];
  endfunction

  // Mostly clusters around the cell limit with spreads near the deltas, so the
  // flag actually swings; the rest is raw noise and boundary values.
  function automatic cell_vec_t random_sample();
    cell_vec_t v;
    int        kind, base, span, i;
    kind = $urandom_range(0, 99);
    base = int'(limits.min_cell_mv) + int'($urandom_range(0, 60)) - 20;
    span = int'(limits.start_delta_mv) + int'(limits.stop_delta_mv) + 8;
    for (i = 0; i < NUM_CELLS; i++) begin
      if (kind < 70) begin
        v[i] = clamp_mv(base + int'($urandom_range(0, span)));
      end else if (kind < 85) begin
        v[i] = MV_W'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0:       v[i] = '0;
          1:       v[i] = MV_FULL_SCALE;
          2:       v[i] = clamp_mv(int'(limits.min_cell_mv) - 1);
          3:       v[i] = limits.min_cell_mv;
          default: v[i] = clamp_mv(int'(limits.min_cell_mv) + 1);
        endcase
      end
    end
    return v;
  endfunction

  task automatic send_sample(input cell_vec_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_cells(input logic [MV_W-1:0] c0, c1, c2, c3);
    send_sample({c3, c2, c1, c0});
  endtask

  // hold until every owed result is back, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_START_DELTA: limits.start_delta_mv = val;
      REG_STOP_DELTA:  limits.stop_delta_mv  = val;
      REG_MIN_CELL:    limits.min_cell_mv    = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [MV_W-1:0] start_mv, stop_mv, min_mv,
                           input int send_pct, recv_pct);
    drain();
    write_reg(REG_START_DELTA, start_mv);
    write_reg(REG_STOP_DELTA, stop_mv);
    write_reg(REG_MIN_CELL, min_mv);
    cfg_we <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (SAMPLES_PER_PHASE) send_sample(random_sample());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds: start 30, stop 10, cell limit 3000
    send_cells(16'd0, 16'd0, 16'd0, 16'd0);
    send_cells(MV_FULL_SCALE, MV_FULL_SCALE, MV_FULL_SCALE, MV_FULL_SCALE);
    send_cells(16'd3000, 16'd3030, 16'd3010, 16'd3025);
    send_cells(16'd3000, 16'd3020, 16'd3015, 16'd3005);
    send_cells(16'd3000, 16'd3011, 16'd3000, 16'd3000);
    send_cells(16'd3000, 16'd3010, 16'd3005, 16'd3000);
    send_cells(16'd3000, 16'd3100, 16'd3100, 16'd3100);
    send_cells(16'd2999, 16'd3100, 16'd3100, 16'd3100);
    send_cells(16'd3000, 16'd3100, 16'd3050, 16'd3098);
    send_cells(16'd3000, 16'd3000, 16'd3000, 16'd3000);
    send_cells(MV_FULL_SCALE, 16'hFFDD, 16'hFFF0, MV_FULL_SCALE);
    send_cells(MV_FULL_SCALE, 16'd0, 16'h8000, MV_FULL_SCALE);

    // zero start delta: equal cells switch on, and half the stop delta exceeds the spread
    drain();
    write_reg(REG_START_DELTA, 16'd0);
    write_reg(REG_STOP_DELTA, 16'd100);
    write_reg(REG_MIN_CELL, 16'd3000);
    write_reg(REG_SPARE, MV_FULL_SCALE);
    cfg_we <= 1'b0;
    send_cells(16'd3001, 16'd3001, 16'd3001, 16'd3001);
    send_cells(16'd3001, 16'd3001, 16'd3001, 16'd3001);
    send_cells(16'd3000, 16'd3000, 16'd3000, 16'd3000);
    send_cells(16'd3000, 16'd3003, 16'd3001, 16'd3000);
    send_cells(16'd3000, 16'd3003, 16'd3001, 16'd3000);

    run_phase(16'd30, 16'd10, 16'd3000, 0, 0);
    run_phase(16'd30, 16'd11, 16'd3000, 68, 0);
    run_phase(16'd0, 16'd0, 16'd0, 0, 68);
    run_phase(MV_FULL_SCALE, MV_FULL_SCALE, MV_FULL_SCALE, 33, 33);
    run_phase(16'd0, MV_FULL_SCALE, 16'd0, 0, 0);
    run_phase(MV_FULL_SCALE, 16'd0, 16'd3000, 68, 0);
    run_phase(MV_W'($urandom_range(0, 300)), MV_W'($urandom_range(0, 300)),
              MV_W'($urandom_range(2800, 4300)), 0, 68);
    run_phase(MV_W'($urandom_range(0, 300)), MV_W'($urandom_range(0, 300)),
              MV_W'($urandom_range(2800, 4300)), 33, 33);
    run_phase(MV_W'($urandom_range(0, 300)), MV_W'($urandom_range(0, 300)),
              MV_W'($urandom_range(2800, 4300)), 0, 0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
src/cbh_pkg.sv
src/cbh_extrema.sv
src/cbh_decide.sv
src/cell_balance_hysteresis.sv
tb/balance_monitor.sv
tb/cell_balance_hysteresis_test.sv
